// ===== sv/jsu_pkg.sv =====
// ----------------------------------------------------------------------------
// JSON string unescape package
// Shared types, codes and helper functions for the string unescape core.
// ----------------------------------------------------------------------------
package jsu_pkg;

    // Text characters that the decoder recognizes.
    localparam logic [7:0] C_QUOTE     = 8'h22;
    localparam logic [7:0] C_BACKSLASH = 8'h5C;
    localparam logic [7:0] C_SLASH     = 8'h2F;
    localparam logic [7:0] C_LOWER_U   = 8'h75;
    localparam logic [7:0] C_LOWER_B   = 8'h62;
    localparam logic [7:0] C_LOWER_F   = 8'h66;
    localparam logic [7:0] C_LOWER_N   = 8'h6E;
    localparam logic [7:0] C_LOWER_R   = 8'h72;
    localparam logic [7:0] C_LOWER_T   = 8'h74;

    // Most bytes that one input word can produce.
    localparam int unsigned MAX_RESULTS = 3;

    // Decoder phase.
    typedef enum logic [1:0] {
        PH_WAIT = 2'd0,
        PH_BODY = 2'd1,
        PH_ESC  = 2'd2,
        PH_HEX  = 2'd3
    } t_phase;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_DATA = 2'd0,
        ST_DONE = 2'd1,
        ST_END  = 2'd2,
        ST_BADU = 2'd3
    } t_status;

    // Input word.
    typedef struct packed {
        logic [7:0] text_byte;
        logic       data_end;
    } t_in_word;

    // Output word.
    typedef struct packed {
        logic [7:0] out_byte;
        logic [1:0] status;
        logic       last_of_run;
    } t_out_word;

    // All results caused by one input word.
    typedef struct packed {
        logic [1:0]                        count;
        t_status                           status;
        logic [MAX_RESULTS-1:0][7:0]       bytes;
    } t_res_grp;

    // Hex digit value; bit 4 is set when the character is not a hex digit.
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] v;
        if (c >= 8'h30 && c <= 8'h39) begin
            v = {1'b0, 4'(c - 8'h30)};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            v = {1'b0, 4'(c - 8'h57)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            v = {1'b0, 4'(c - 8'h37)};
        end else begin
            v = 5'h10;
        end
        return v;
    endfunction

endpackage

// ===== sv/jsu_decode.sv =====
// ----------------------------------------------------------------------------
// JSON string unescape decoder
// Holds the parse state and turns one input word into its group of results.
// ----------------------------------------------------------------------------
module jsu_decode (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_advance,
    input  jsu_pkg::t_in_word i_word,
    output jsu_pkg::t_res_grp o_grp
);
    import jsu_pkg::*;

    t_phase      r_phase,      n_phase;
    logic [1:0]  r_hex_count,  n_hex_count;
    logic [15:0] r_code_accum, n_code_accum;
    logic        r_bad,        n_bad;

    logic [7:0]  c;
    logic [4:0]  digit;

    assign c     = i_word.text_byte;
    assign digit = hex_value(c);

    // Next state and result group for the word in the input register.
    always_comb begin
        n_phase      = r_phase;
        n_hex_count  = r_hex_count;
        n_code_accum = r_code_accum;
        n_bad        = r_bad;
        o_grp        = '0;
        o_grp.status = ST_DATA;

        if (i_word.data_end) begin
            o_grp.count  = 2'd1;
            o_grp.status = ST_END;
            n_phase      = PH_WAIT;
        end else begin
            unique case (r_phase)
                PH_WAIT: begin
                    n_phase = PH_BODY;
                end
                PH_BODY: begin
                    if (c == C_QUOTE) begin
                        o_grp.count  = 2'd1;
                        o_grp.status = ST_DONE;
                        n_phase      = PH_WAIT;
                    end else if (c == C_BACKSLASH) begin
                        n_phase = PH_ESC;
                    end else begin
                        o_grp.count    = 2'd1;
                        o_grp.bytes[0] = c;
                    end
                end
                PH_ESC: begin
                    n_phase = PH_BODY;
                    if (c == C_LOWER_U) begin
                        n_hex_count  = 2'd0;
                        n_code_accum = '0;
                        n_bad        = 1'b0;
                        n_phase      = PH_HEX;
                    end else begin
                        // Unknown escape characters are dropped.
                        o_grp.count = 2'd1;
                        unique case (c)
                            C_QUOTE:     o_grp.bytes[0] = C_QUOTE;
                            C_BACKSLASH: o_grp.bytes[0] = C_BACKSLASH;
                            C_SLASH:     o_grp.bytes[0] = C_SLASH;
                            C_LOWER_B:   o_grp.bytes[0] = 8'h08;
                            C_LOWER_F:   o_grp.bytes[0] = 8'h0C;
                            C_LOWER_N:   o_grp.bytes[0] = 8'h0A;
                            C_LOWER_R:   o_grp.bytes[0] = 8'h0D;
                            C_LOWER_T:   o_grp.bytes[0] = 8'h09;
                            default:     o_grp.count    = 2'd0;
                        endcase
                    end
                end
                PH_HEX: begin
                    if (!digit[4]) begin
                        n_code_accum = {r_code_accum[11:0], digit[3:0]};
                    end else begin
                        n_bad = 1'b1;
                    end
                    if (r_hex_count == 2'd3) begin
                        n_hex_count = 2'd0;
                        if (n_bad) begin
                            o_grp.count  = 2'd1;
                            o_grp.status = ST_BADU;
                            n_phase      = PH_WAIT;
                        end else begin
                            // UTF-8 encoding of the gathered code point.
                            n_phase = PH_BODY;
                            if (n_code_accum[15:7] == '0) begin
                                o_grp.count    = 2'd1;
                                o_grp.bytes[0] = n_code_accum[7:0];
                            end else if (n_code_accum[15:11] == '0) begin
                                o_grp.count    = 2'd2;
                                o_grp.bytes[0] = {3'b110, n_code_accum[10:6]};
                                o_grp.bytes[1] = {2'b10, n_code_accum[5:0]};
                            end else begin
                                o_grp.count    = 2'd3;
                                o_grp.bytes[0] = {4'b1110, n_code_accum[15:12]};
                                o_grp.bytes[1] = {2'b10, n_code_accum[11:6]};
                                o_grp.bytes[2] = {2'b10, n_code_accum[5:0]};
                            end
                        end
                    end else begin
                        n_hex_count = r_hex_count + 2'd1;
                    end
                end
                default: begin
                    n_phase = PH_WAIT;
                end
            endcase
        end
    end

    // Parse state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_WAIT;
            r_hex_count  <= '0;
            r_code_accum <= '0;
            r_bad        <= 1'b0;
        end else if (i_advance) begin
            r_phase      <= n_phase;
            r_hex_count  <= n_hex_count;
            r_code_accum <= n_code_accum;
            r_bad        <= n_bad;
        end
    end

    // An end of data always returns the decoder to waiting for a quote.
    a_end_to_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_advance && i_word.data_end |=> r_phase == PH_WAIT)
        else $error("phase did not return to wait after end of data");

    // The digit count only moves while gathering hex digits.
    a_hex_count_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_advance && r_phase != PH_HEX && !(r_phase == PH_ESC && c == C_LOWER_U)
        |=> $stable(r_hex_count))
        else $error("hex digit count changed outside a unicode escape");

endmodule

// ===== sv/jsu_out_buf.sv =====
// ----------------------------------------------------------------------------
// JSON string unescape result buffer
// Holds one group of results and hands them out one word at a time.
// ----------------------------------------------------------------------------
module jsu_out_buf (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  jsu_pkg::t_res_grp  i_grp,
    output logic               o_free,
    output logic               o_valid,
    input  logic               i_ready,
    output jsu_pkg::t_out_word o_word
);
    import jsu_pkg::*;

    logic [1:0]                  r_left;
    logic [1:0]                  r_pos;
    t_status                     r_status;
    logic [MAX_RESULTS-1:0][7:0] r_bytes;
    logic [7:0]                  cur_byte;
    logic                        take;

    assign o_valid = (r_left != 2'd0);
    assign take    = o_valid && i_ready;
    assign o_free  = (r_left == 2'd0) || (r_left == 2'd1 && i_ready);

    // Select the byte at the current read position.
    always_comb begin
        unique case (r_pos)
            2'd1:    cur_byte = r_bytes[1];
            2'd2:    cur_byte = r_bytes[2];
            default: cur_byte = r_bytes[0];
        endcase
    end

    always_comb begin
        o_word.out_byte    = cur_byte;
        o_word.status      = r_status;
        o_word.last_of_run = (r_left == 2'd1);
    end

    // Count and position of the words still to deliver.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= '0;
            r_pos  <= '0;
        end else if (i_load) begin
            r_left <= i_grp.count;
            r_pos  <= '0;
        end else if (take) begin
            r_left <= r_left - 2'd1;
            r_pos  <= r_pos + 2'd1;
        end
    end

    // Payload of the group.
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_status <= i_grp.status;
            r_bytes  <= i_grp.bytes;
        end
    end

    // A new group never overwrites words that are still waiting.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> o_free)
        else $error("result group loaded over pending words");

    // The read position never runs past the stored bytes.
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_pos} + {1'b0, r_left} <= 3'd3)
        else $error("read position beyond the result group");

endmodule

// ===== sv/json_string_unescape_core.sv =====
// One JSON text byte is accepted per cycle unless the result buffer is still
// busy; a word enters an input register, is decoded from that register and
// its results are loaded into the result buffer, which drives the output.
// A word that yields one result or none keeps the full rate of one word per
// cycle while the output is ready. A \u escape that expands to two or three
// UTF-8 bytes holds the input, because the result buffer delivers at most one
// word per cycle and takes the next group only as its last word leaves.
// ----------------------------------------------------------------------------
// JSON string unescape core
// Decodes quoted JSON strings byte by byte into raw bytes plus status words.
// ----------------------------------------------------------------------------
module json_string_unescape_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  jsu_pkg::t_in_word  i_in_word,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output jsu_pkg::t_out_word o_out_word
);
    import jsu_pkg::*;

    logic     r_in_valid;
    t_in_word r_in_word;
    logic     grp_free;
    logic     advance;
    t_res_grp grp;

    // The registered word moves on once the result buffer can take its group.
    assign advance    = r_in_valid && grp_free;
    assign o_in_ready = !r_in_valid || advance;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_word <= i_in_word;
        end
    end

    jsu_decode u_decode (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_word    (r_in_word),
        .o_grp     (grp)
    );

    jsu_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (advance),
        .i_grp   (grp),
        .o_free  (grp_free),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_word  (o_out_word)
    );

    // A held input word is never dropped while the buffer is busy.
    a_hold_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !grp_free |=> r_in_valid && $stable(r_in_word))
        else $error("input word lost while result buffer was busy");

    // Only data words carry a nonzero byte.
    a_status_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.status != ST_DATA |-> o_out_word.out_byte == 8'h00)
        else $error("status word carries a data byte");

endmodule
